// ===== rtl/assert_macros.svh =====
// assertion macros used by the pacer rtl
// depends on nothing; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a in a cycle implies condition c in the same cycle
`define HKP_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed: same-cycle implication");

// condition a in a cycle implies condition c in the next cycle
`define HKP_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/hkp_pkg.sv =====
// types and constants of the key event pacer
// depends on nothing; used by every rtl module of the block
package hkp_pkg;

	// width of a wait in microseconds: 65535 ms times 1000 fits in 26 bits
	localparam int WAIT_W = 26;
	localparam int LEVEL_W = 7;
	localparam logic [WAIT_W-1:0] MS_TO_US = WAIT_W'(1000);
	localparam logic [15:0] GUARD_RESET = 16'd4000;

	// item kinds
	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_POLL = 1'b1
	} cmd_kind_t;

	// result codes
	typedef enum logic [2:0] {
		ST_PUSHED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_REPORT  = 3'd2,
		ST_WAIT    = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_EXEC,
		ENG_ADD
	} eng_state_t;

	// one classified item waiting for the back end
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  key_modifier;
		logic [7:0]  key_code;
		logic [15:0] hold_ms;
		logic [63:0] now_us;
		logic        host_ready;
	} cmd_t;

	// one stored key event
	typedef struct packed {
		logic [15:0] hold_ms;
		logic [7:0]  key_code;
		logic [7:0]  key_modifier;
	} event_t;

	// one result item
	typedef struct packed {
		status_t              status;
		logic [7:0]           report_modifier;
		logic [7:0]           report_key;
		logic [LEVEL_W-1:0]   queue_level;
	} result_t;

endpackage

// ===== rtl/hid_key_event_pacer.sv =====
// top level of the key event pacer: front queue, engine, result queue
// depends on hkp_pkg, hkp_front, hkp_engine, hkp_result_queue, assert_macros.svh
`include "assert_macros.svh"

// Key event pacer. Push items (opcode 0) queue key events in a store of
// QUEUE_DEPTH entries; poll items (opcode 1) send a report, release a held key
// or start a wait once the host is ready and the deadline has passed. Every
// item gives exactly one result, in order. Items enter a two-entry front queue
// and results leave through a two-entry result queue, so both sides may stall
// freely. The engine works on one item at a time: it acts in the execute
// state (registered event store read), and a poll that acts then does the
// 64-bit saturating deadline add in the add state. The guard time register
// may be written only while no item is in flight; it resets to 4000 us.
module hid_key_event_pacer #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [7:0]  key_modifier,
	input  logic [7:0]  key_code,
	input  logic [15:0] hold_ms,
	input  logic [63:0] now_us,
	input  logic        host_ready,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [7:0]  report_modifier,
	output logic [7:0]  report_key,
	output logic [6:0]  queue_level,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic              [15:0] guard_q;
	logic                     cmd_empty;
	logic                     cmd_pop;
	hkp_pkg::cmd_t            cmd_head;
	logic                     res_full;
	logic                     res_push;
	hkp_pkg::result_t         res_data;
	hkp_pkg::result_t         res_head;

	// guard time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			guard_q <= hkp_pkg::GUARD_RESET;
		else if (cfg_wr_en)
			guard_q <= cfg_wr_data;
	end

	hkp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.key_modifier (key_modifier),
		.key_code     (key_code),
		.hold_ms      (hold_ms),
		.now_us       (now_us),
		.host_ready   (host_ready),
		.cmd_empty    (cmd_empty),
		.cmd_head     (cmd_head),
		.cmd_pop      (cmd_pop)
	);

	hkp_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.guard_time_us (guard_q),
		.cmd_empty     (cmd_empty),
		.cmd_head      (cmd_head),
		.cmd_pop       (cmd_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res_data      (res_data)
	);

	hkp_result_queue u_results (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_data (res_data),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (res_head)
	);

	// result ports
	assign status          = res_head.status;
	assign report_modifier = res_head.report_modifier;
	assign report_key      = res_head.report_key;
	assign queue_level     = res_head.queue_level;

	// checks
	`HKP_ASSERT_SAME(a_no_result_overflow, clk, arst_n, res_push, !res_full)
	`HKP_ASSERT_SAME(a_no_empty_take, clk, arst_n, cmd_pop, !cmd_empty)
	`HKP_ASSERT_NEXT(a_one_in_flight, clk, arst_n, cmd_pop, !cmd_pop)
	`HKP_ASSERT_SAME(a_quiet_unless_report, clk, arst_n,
		!empty && status != hkp_pkg::ST_REPORT,
		report_modifier == 8'd0 && report_key == 8'd0)

endmodule

// ===== rtl/hkp_front.sv =====
// front end: accepts items, classifies them and holds them in a two-entry queue
// depends on hkp_pkg
module hkp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             opcode,
	input  logic [7:0]       key_modifier,
	input  logic [7:0]       key_code,
	input  logic [15:0]      hold_ms,
	input  logic [63:0]      now_us,
	input  logic             host_ready,
	output logic             cmd_empty,
	output hkp_pkg::cmd_t    cmd_head,
	input  logic             cmd_pop
);

	hkp_pkg::cmd_t ent_q [2];
	hkp_pkg::cmd_t cmd_in;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	// classify the incoming item
	always_comb begin
		cmd_in.kind         = hkp_pkg::cmd_kind_t'(opcode);
		cmd_in.key_modifier = key_modifier;
		cmd_in.key_code     = key_code;
		cmd_in.hold_ms      = hold_ms;
		cmd_in.now_us       = now_us;
		cmd_in.host_ready   = host_ready;
	end

	// handshake
	assign full      = (cnt_q == 2'd2);
	assign cmd_empty = (cnt_q == 2'd0);
	assign do_wr     = push && !full;
	assign do_rd     = cmd_pop && !cmd_empty;
	assign cmd_head  = ent_q[rd_ptr_q];

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ===== rtl/hkp_engine.sv =====
// back end: event store, deadline and held-key state, one item at a time
// depends on hkp_pkg
module hkp_engine #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       guard_time_us,
	input  logic              cmd_empty,
	input  hkp_pkg::cmd_t     cmd_head,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output hkp_pkg::result_t  res_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [31:0]                 mem [QUEUE_DEPTH];
	logic [31:0]                 rdata_q;
	hkp_pkg::cmd_t               cmd_q;
	hkp_pkg::eng_state_t         state_q, state_d;
	logic [AW-1:0]               rd_ptr_q, rd_ptr_d, rd_ptr_inc;
	logic [AW-1:0]               wr_ptr_q, wr_ptr_d, wr_ptr_inc;
	logic [CW-1:0]               count_q, count_d;
	logic [63:0]                 nat_q, nat_d;
	logic                        held_q, held_d;
	logic [hkp_pkg::WAIT_W-1:0]  wait_q, wait_d;
	hkp_pkg::status_t            stat_q, stat_d;
	logic [7:0]                  mod_q, mod_d;
	logic [7:0]                  key_q, key_d;
	logic                        mem_we;
	logic                        start;
	logic                        go;
	logic                        act;
	logic                        q_full;
	hkp_pkg::event_t             ev;
	logic [64:0]                 sum_wide;
	logic [CW+hkp_pkg::LEVEL_W-1:0] lvl_ext;

	// shared conditions
	assign start      = !cmd_empty && !res_full;
	assign ev         = hkp_pkg::event_t'(rdata_q);
	assign go         = cmd_q.host_ready && (cmd_q.now_us >= nat_q);
	assign act        = go && (held_q || (count_q != '0));
	assign q_full     = (count_q == CW'(QUEUE_DEPTH));
	assign rd_ptr_inc = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
	assign wr_ptr_inc = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign sum_wide   = {1'b0, cmd_q.now_us} + 65'(wait_q);
	assign lvl_ext    = {{hkp_pkg::LEVEL_W{1'b0}}, count_d};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hkp_pkg::ENG_IDLE: begin
				if (start)
					state_d = hkp_pkg::ENG_EXEC;
			end
			hkp_pkg::ENG_EXEC: begin
				if (cmd_q.kind == hkp_pkg::CMD_POLL && act)
					state_d = hkp_pkg::ENG_ADD;
				else
					state_d = hkp_pkg::ENG_IDLE;
			end
			hkp_pkg::ENG_ADD: state_d = hkp_pkg::ENG_IDLE;
			default: state_d = hkp_pkg::ENG_IDLE;
		endcase
	end

	// actions and result of each state
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		mem_we   = 1'b0;
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		count_d  = count_q;
		nat_d    = nat_q;
		held_d   = held_q;
		wait_d   = wait_q;
		stat_d   = hkp_pkg::ST_NONE;
		mod_d    = 8'd0;
		key_d    = 8'd0;
		unique case (state_q)
			hkp_pkg::ENG_IDLE: begin
				cmd_pop = start;
			end
			hkp_pkg::ENG_EXEC: begin
				if (cmd_q.kind == hkp_pkg::CMD_PUSH) begin
					res_push = 1'b1;
					if (q_full) begin
						stat_d = hkp_pkg::ST_DROPPED;
					end else begin
						mem_we   = 1'b1;
						wr_ptr_d = wr_ptr_inc;
						count_d  = count_q + CW'(1);
						stat_d   = hkp_pkg::ST_PUSHED;
					end
				end else if (!act) begin
					// not ready, too early, or nothing to do
					res_push = 1'b1;
				end else if (held_q) begin
					// automatic release report
					held_d = 1'b0;
					wait_d = hkp_pkg::WAIT_W'(guard_time_us);
					stat_d = hkp_pkg::ST_REPORT;
				end else begin
					// pop one event
					rd_ptr_d = rd_ptr_inc;
					count_d  = count_q - CW'(1);
					wait_d   = hkp_pkg::WAIT_W'(ev.hold_ms) * hkp_pkg::MS_TO_US;
					if (ev.key_code == 8'd0 && ev.hold_ms != 16'd0) begin
						stat_d = hkp_pkg::ST_WAIT;
					end else begin
						stat_d = hkp_pkg::ST_REPORT;
						mod_d  = ev.key_modifier;
						key_d  = ev.key_code;
						held_d = (ev.key_code != 8'd0);
					end
				end
			end
			hkp_pkg::ENG_ADD: begin
				// saturating deadline update
				res_push = 1'b1;
				nat_d    = sum_wide[64] ? '1 : sum_wide[63:0];
				stat_d   = stat_q;
				mod_d    = mod_q;
				key_d    = key_q;
			end
			default: ;
		endcase
	end

	// result item
	always_comb begin
		res_data.status          = stat_d;
		res_data.report_modifier = mod_d;
		res_data.report_key      = key_d;
		res_data.queue_level     = lvl_ext[hkp_pkg::LEVEL_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hkp_pkg::ENG_IDLE;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			nat_q    <= '0;
			held_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			count_q  <= count_d;
			nat_q    <= nat_d;
			held_q   <= held_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == hkp_pkg::ENG_IDLE)
			cmd_q <= cmd_head;
		wait_q <= wait_d;
		stat_q <= stat_d;
		mod_q  <= mod_d;
		key_q  <= key_d;
	end

	// event store, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_ptr_q] <= {cmd_q.hold_ms, cmd_q.key_code, cmd_q.key_modifier};
		rdata_q <= mem[rd_ptr_q];
	end

endmodule

// ===== rtl/hkp_result_queue.sv =====
// two-entry result queue between the back end and the result ports
// depends on hkp_pkg
module hkp_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  hkp_pkg::result_t  res_data,
	output logic              res_full,
	output logic              empty,
	input  logic              pop,
	output hkp_pkg::result_t  head
);

	hkp_pkg::result_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	// handshake
	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_wr    = res_push && !res_full;
	assign do_rd    = pop && !empty;
	assign head     = ent_q[rd_ptr_q];

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wr_ptr_q] <= res_data;
	end

endmodule
